// ===== hdl/midi_jitter_clock_follower_macros.svh =====
// ---------------------------------------------------------------------------
// MIDI jitter clock follower assertion macros
// Shared property shorthands for the follower and its output pipeline.
// ---------------------------------------------------------------------------
`ifndef MIDI_JITTER_CLOCK_FOLLOWER_MACROS_SVH
`define MIDI_JITTER_CLOCK_FOLLOWER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MJCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MJCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mjcf_pkg.sv =====
// ---------------------------------------------------------------------------
// mjcf_pkg
// Types and fixed constants shared by the jitter clock follower modules.
// ---------------------------------------------------------------------------
package mjcf_pkg;

    localparam int MODE_W      = 2;
    localparam int STAMP_W     = 16;
    localparam int PORT_TIME_W = 48;
    localparam int GUARD_W     = 32;
    localparam int CFG_W       = 20;

    // Item kinds carried on tuser
    localparam logic [MODE_W-1:0] MODE_CLOCK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MSG     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    localparam logic [GUARD_W-1:0] JIT_MAX     = 32'hFFFF_FFFF;
    localparam logic [CFG_W-1:0]   GUARD_RESET = 20'd2000;

    // floor(x / 5) = (x * RECIP5) >> RECIP5_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
    localparam int          RECIP5_SHIFT = 34;

    // Guard sources captured with a message item
    typedef struct packed {
        logic [GUARD_W-1:0] jitter;
        logic [CFG_W-1:0]   base;
    } guard_src_t;

endpackage

// ===== hdl/mjcf_follower.sv =====
// ---------------------------------------------------------------------------
// mjcf_follower
// Clock-follower state: expected clock, message time, jitter estimate and
// the guard base, updated once per retired item.
// ---------------------------------------------------------------------------
`include "midi_jitter_clock_follower_macros.svh"

module mjcf_follower #(
    parameter int TICK_US   = 32,
    parameter int TIME_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [mjcf_pkg::MODE_W-1:0]   mode,
    input  logic [TIME_BITS-1:0]          rx,
    input  logic [mjcf_pkg::STAMP_W-1:0]  stamp,
    input  logic [mjcf_pkg::CFG_W-1:0]    cfg_guard,
    output logic [TIME_BITS-1:0]          msg_time,
    output mjcf_pkg::guard_src_t          src
);
    import mjcf_pkg::*;

    localparam int TICK_W = $clog2(TICK_US + 1);
    localparam int PROD_W = STAMP_W + TICK_W;
    localparam logic [TICK_W-1:0] TICK_C = TICK_W'(TICK_US);

    logic                 started_reg, started_next;
    logic [TIME_BITS-1:0] clock_time_reg, clock_time_next;
    logic [STAMP_W-1:0]   clock_stamp_reg, clock_stamp_next;
    logic [TIME_BITS-1:0] message_time_reg, message_time_next;
    logic [GUARD_W-1:0]   jitter_reg, jitter_next;
    logic [CFG_W-1:0]     base_reg, base_next;

    logic [STAMP_W-1:0]   ticks;
    logic [PROD_W-1:0]    tick_prod;
    logic [TIME_BITS-1:0] predicted;
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] mag;
    logic [TIME_BITS-1:0] d_rx_msg;
    logic [TIME_BITS-1:0] d_pred_msg;
    logic                 rx_later;
    logic                 pred_later;
    logic [GUARD_W:0]     jit_sum;
    logic [GUARD_W-1:0]   jit_grow;
    logic [GUARD_W-1:0]   diff_sat;

    // Predicted receive time from the wrapped stamp difference
    assign ticks     = stamp - clock_stamp_reg;
    assign tick_prod = PROD_W'(ticks) * PROD_W'(TICK_C);
    assign predicted = clock_time_reg + TIME_BITS'(tick_prod);

    assign diff = rx - predicted;
    assign mag  = '0 - diff;

    assign d_rx_msg   = rx - message_time_reg;
    assign d_pred_msg = predicted - message_time_reg;
    assign rx_later   = (d_rx_msg != '0) && !d_rx_msg[TIME_BITS-1];
    assign pred_later = (d_pred_msg != '0) && !d_pred_msg[TIME_BITS-1];

    // Early arrival: grow jitter by the lead, saturating
    assign jit_sum  = {1'b0, jitter_reg} + {1'b0, mag[GUARD_W-1:0]};
    assign jit_grow = (((mag >> GUARD_W) != '0) || jit_sum[GUARD_W])
                      ? JIT_MAX : jit_sum[GUARD_W-1:0];
    // Late arrival: lag, saturating
    assign diff_sat = ((diff >> GUARD_W) != '0) ? JIT_MAX : diff[GUARD_W-1:0];

    always_comb
    begin
        started_next      = started_reg;
        clock_time_next   = clock_time_reg;
        clock_stamp_next  = clock_stamp_reg;
        message_time_next = message_time_reg;
        jitter_next       = jitter_reg;
        base_next         = base_reg;
        if (step)
        begin
            unique case (mode)
                MODE_CLOCK:
                begin
                    clock_stamp_next = stamp;
                    if (!started_reg)
                    begin
                        started_next      = 1'b1;
                        clock_time_next   = rx;
                        message_time_next = rx;
                    end
                    else if (diff[TIME_BITS-1])
                    begin
                        clock_time_next = rx;
                        if (rx_later)
                        begin
                            message_time_next = rx;
                        end
                        jitter_next = jit_grow;
                    end
                    else
                    begin
                        clock_time_next   = predicted;
                        message_time_next = rx;
                        if (diff_sat > jitter_reg)
                        begin
                            jitter_next = diff_sat;
                        end
                    end
                end
                MODE_MSG:
                begin
                    if (!started_reg)
                    begin
                        message_time_next = rx;
                    end
                    else if (pred_later)
                    begin
                        message_time_next = predicted;
                    end
                end
                MODE_RESTART:
                begin
                    started_next      = 1'b0;
                    clock_time_next   = '0;
                    clock_stamp_next  = '0;
                    message_time_next = '0;
                    jitter_next       = '0;
                    base_next         = cfg_guard;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg      <= 1'b0;
            clock_time_reg   <= '0;
            clock_stamp_reg  <= '0;
            message_time_reg <= '0;
            jitter_reg       <= '0;
            base_reg         <= GUARD_RESET;
        end
        else
        begin
            started_reg      <= started_next;
            clock_time_reg   <= clock_time_next;
            clock_stamp_reg  <= clock_stamp_next;
            message_time_reg <= message_time_next;
            jitter_reg       <= jitter_next;
            base_reg         <= base_next;
        end
    end

    // A message leaves jitter and base untouched, so the registered values
    // are the ones in force for it.
    assign msg_time   = message_time_next;
    assign src.jitter = jitter_reg;
    assign src.base   = base_reg;

    `MJCF_ASSERT_NEXT(a_jitter_monotone, clk, rst_n,
        step && (mode != MODE_RESTART), jitter_reg >= $past(jitter_reg),
        "jitter estimate shrank without a restart")
    `MJCF_ASSERT_NEXT(a_restart_clears, clk, rst_n,
        step && (mode == MODE_RESTART), !started_reg && (jitter_reg == '0),
        "restart did not clear the follower")

endmodule

// ===== hdl/mjcf_guard_pipe.sv =====
// ---------------------------------------------------------------------------
// mjcf_guard_pipe
// Guard and play-time pipeline for message items, with output register.
// ---------------------------------------------------------------------------
`include "midi_jitter_clock_follower_macros.svh"

module mjcf_guard_pipe #(
    parameter int TIME_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic [TIME_BITS-1:0]              msg_time,
    input  mjcf_pkg::guard_src_t              src,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mjcf_pkg::PORT_TIME_W-1:0]  play_time,
    output logic [mjcf_pkg::GUARD_W-1:0]      current_guard
);
    import mjcf_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg, ov_reg;
    logic                 r1, r2, r3, ready_out;

    logic [TIME_BITS-1:0] t1_reg, t2_reg, t3_reg;
    guard_src_t           s1_reg;
    logic [GUARD_W-1:0]   j2_reg, q2_reg;
    logic [CFG_W-1:0]     b2_reg;
    logic [GUARD_W-1:0]   g3_reg;
    logic [PORT_TIME_W-1:0] play_reg;
    logic [GUARD_W-1:0]   guard_reg;

    logic [63:0]          recip_prod;
    logic [GUARD_W:0]     scale_sum;
    logic [GUARD_W-1:0]   scaled;
    logic [GUARD_W-1:0]   guard_next;
    logic [TIME_BITS-1:0] play_next;

    assign ready_out = !ov_reg || out_ready;
    assign r3        = !v3_reg || ready_out;
    assign r2        = !v2_reg || r3;
    assign r1        = !v1_reg || r2;
    assign in_ready  = r1;

    // jitter * 12 / 10 = jitter + floor(jitter / 5)
    assign recip_prod = 64'(s1_reg.jitter) * 64'(RECIP5);
    assign scale_sum  = {1'b0, j2_reg} + {1'b0, q2_reg};
    assign scaled     = scale_sum[GUARD_W] ? JIT_MAX : scale_sum[GUARD_W-1:0];
    assign guard_next = (scaled > GUARD_W'(b2_reg)) ? scaled : GUARD_W'(b2_reg);
    assign play_next  = t3_reg + TIME_BITS'(g3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= push;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready_out)
            begin
                ov_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && push)
        begin
            t1_reg <= msg_time;
            s1_reg <= src;
        end
        if (r2 && v1_reg)
        begin
            t2_reg <= t1_reg;
            j2_reg <= s1_reg.jitter;
            b2_reg <= s1_reg.base;
            q2_reg <= GUARD_W'(recip_prod >> RECIP5_SHIFT);
        end
        if (r3 && v2_reg)
        begin
            t3_reg <= t2_reg;
            g3_reg <= guard_next;
        end
        if (ready_out && v3_reg)
        begin
            play_reg  <= PORT_TIME_W'(play_next);
            guard_reg <= g3_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign play_time     = play_reg;
    assign current_guard = guard_reg;

    `MJCF_ASSERT_NOW(a_push_has_room, clk, rst_n,
        push, r1,
        "message pushed into a full guard stage")
    `MJCF_ASSERT_NOW(a_recip_bound, clk, rst_n,
        v2_reg, q2_reg <= (j2_reg >> 2),
        "jitter fifth out of range")

endmodule

// ===== hdl/midi_jitter_clock_follower.sv =====
// ---------------------------------------------------------------------------
// midi_jitter_clock_follower
// Schedules MIDI messages against a sender's jitter-reduction clock stamps.
// ---------------------------------------------------------------------------
// Takes one item per clock on the slave stream unless a message finds no
// room in the guard stages: the follower state (expected clock, last message
// time, jitter estimate) is updated when the registered item retires, and a
// message's play time then passes through the guard stages and the output
// register to the master stream. The guard pipeline holds one stage for the
// jitter/5 reciprocal multiply, one for the saturating x1.2 scale and guard
// select, one for the play-time add into the output register. Clock stamps
// and restarts produce no output item; unused kind 3 is dropped.
// Back-pressure on the master side fills the guard stages before the slave
// side stalls. The guard loaded at restart comes from cfg_wr_data, and at
// reset it is GUARD_RESET; write it only while the block is idle.
// ---------------------------------------------------------------------------
module midi_jitter_clock_follower #(
    parameter int TICK_US   = 32,
    parameter int TIME_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: initial guard in microseconds
    input  logic        cfg_wr_en,
    input  logic [19:0] cfg_wr_data,
    // Slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [47:0] received_time, [63:48] stamp
    input  logic [1:0]  s_tuser,    // [1:0] mode
    // Master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata     // [47:0] play_time, [79:48] current_guard
);
    import mjcf_pkg::*;

    logic [CFG_W-1:0]     cfg_guard_reg;

    // Input register
    logic                 v0_reg;
    logic [MODE_W-1:0]    mode0_reg;
    logic [TIME_BITS-1:0] rx0_reg;
    logic [STAMP_W-1:0]   stamp0_reg;

    logic                 r0;
    logic                 pipe_ready;
    logic                 step;
    logic                 push;
    logic [TIME_BITS-1:0] msg_time;
    guard_src_t           src;
    logic [PORT_TIME_W-1:0] play_time;
    logic [GUARD_W-1:0]   current_guard;

    // Hold the configured guard until a restart picks it up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_guard_reg <= GUARD_RESET;
        end
        else if (cfg_wr_en)
        begin
            cfg_guard_reg <= cfg_wr_data;
        end
    end

    // The registered item retires unless it is a message with no room below
    assign r0       = !v0_reg || (mode0_reg != MODE_MSG) || pipe_ready;
    assign s_tready = r0;
    assign step     = v0_reg && r0;
    assign push     = step && (mode0_reg == MODE_MSG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (r0)
        begin
            v0_reg <= s_tvalid;
        end
    end

    // Take received time into the follower's time width
    always_ff @(posedge clk)
    begin
        if (r0 && s_tvalid)
        begin
            mode0_reg  <= s_tuser;
            rx0_reg    <= TIME_BITS'(s_tdata[PORT_TIME_W-1:0]);
            stamp0_reg <= s_tdata[PORT_TIME_W+STAMP_W-1:PORT_TIME_W];
        end
    end

    mjcf_follower #(
        .TICK_US   (TICK_US),
        .TIME_BITS (TIME_BITS)
    ) u_follower (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .mode      (mode0_reg),
        .rx        (rx0_reg),
        .stamp     (stamp0_reg),
        .cfg_guard (cfg_guard_reg),
        .msg_time  (msg_time),
        .src       (src)
    );

    mjcf_guard_pipe #(
        .TIME_BITS (TIME_BITS)
    ) u_guard_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .msg_time      (msg_time),
        .src           (src),
        .in_ready      (pipe_ready),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .play_time     (play_time),
        .current_guard (current_guard)
    );

    assign m_tdata = {current_guard, play_time};

endmodule
